// ===== hdl/rcpw_pkg.sv =====
// Package: shared types, constants and codes for the RC pulse-width decoder.
`timescale 1ns / 1ps

package rcpw_pkg;

	localparam int WidthW   = 15;
	localparam int NarrowW  = 10;
	localparam int CmdW     = 11;
	localparam int ProdW    = WidthW + NarrowW;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 15;
	localparam int DivSteps = ProdW;
	localparam int DivCntW  = $clog2(DivSteps);

	localparam logic [NarrowW-1:0] DeadbandRst  = NarrowW'(0);
	localparam logic [WidthW-1:0]  CenterRst    = WidthW'(1500);
	localparam logic [WidthW-1:0]  HalfSpanRst  = WidthW'(500);
	localparam logic [NarrowW-1:0] OutRangeRst  = NarrowW'(1000);
	localparam logic [WidthW-1:0]  PulseMinRst  = WidthW'(800);
	localparam logic [WidthW-1:0]  PulseMaxRst  = WidthW'(2200);

	typedef enum logic [CfgIdxW-1:0] {
		REG_DEADBAND  = 3'd0,
		REG_CENTER    = 3'd1,
		REG_HALF_SPAN = 3'd2,
		REG_OUT_RANGE = 3'd3,
		REG_PULSE_MIN = 3'd4,
		REG_PULSE_MAX = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		OP_SYMBOL = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [ProdW-1:0]  dividend;
		logic [WidthW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [ProdW-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hdl/rcpw_req_if.sv =====
// Interface: input item channel (symbols and read requests).
`timescale 1ns / 1ps

interface rcpw_req_if;
	import rcpw_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic              level_first;
	logic [WidthW-1:0] width_first;
	logic              level_second;
	logic [WidthW-1:0] width_second;

	modport source (
		output valid, operation, level_first, width_first, level_second, width_second,
		input  ready
	);
	modport sink (
		input  valid, operation, level_first, width_first, level_second, width_second,
		output ready
	);
endinterface

// ===== hdl/rcpw_rsp_if.sv =====
// Interface: result item channel.
`timescale 1ns / 1ps

interface rcpw_rsp_if;
	import rcpw_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   has_value;
	logic signed [CmdW-1:0] command;

	modport source (
		output valid, has_value, command,
		input  ready
	);
	modport sink (
		input  valid, has_value, command,
		output ready
	);
endinterface

// ===== hdl/rcpw_cfg_if.sv =====
// Interface: configuration register write channel.
`timescale 1ns / 1ps

interface rcpw_cfg_if;
	import rcpw_pkg::*;

	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ===== hdl/rcpw_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rcpw_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rcpw_pkg::div_req_t  req,
	output rcpw_pkg::div_rsp_t  rsp
);
	import rcpw_pkg::*;

	logic [ProdW-1:0]  dvd_q;
	logic [WidthW-1:0] rem_q;
	logic [WidthW-1:0] dsr_q;
	logic [DivCntW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [WidthW:0]   shifted;
	logic [WidthW+1:0] trial;
	logic              fits;

	assign shifted = {rem_q, dvd_q[ProdW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dsr_q};
	assign fits    = !trial[WidthW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DivCntW'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ProdW-2:0], fits};
			rem_q <= fits ? trial[WidthW-1:0] : shifted[WidthW-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// ===== hdl/rc_pulse_width_to_command.sv =====
// Top level: RC pulse-width decoder with command scaling on read.
`timescale 1ns / 1ps

// A symbol item's high width is picked, checked against [pulse_min,
// pulse_max] and stored with a fresh flag. A read item with no fresh
// pulse goes straight to the output state; with a fresh pulse it runs
// one multiply of |pulse - center| by out_range, then the serial divider
// by half_span_us, then clamp, deadband and sign. With half_span_us at
// zero the divider is skipped. Input ready is low while a read is being
// worked on or its result has not yet been taken. Configuration writes
// are always ready.
module rc_pulse_width_to_command (
	input  logic         clk,
	input  logic         arst_n,
	rcpw_req_if.sink     req,
	rcpw_rsp_if.source   rsp,
	rcpw_cfg_if.sink     cfg
);
	import rcpw_pkg::*;

	logic [NarrowW-1:0] deadband_q;
	logic [WidthW-1:0]  center_q;
	logic [WidthW-1:0]  half_span_q;
	logic [NarrowW-1:0] out_range_q;
	logic [WidthW-1:0]  pulse_min_q;
	logic [WidthW-1:0]  pulse_max_q;

	logic [WidthW-1:0]  latest_q;
	logic               fresh_q;

	state_t             state_q, state_d;
	logic               has_q;
	logic               neg_q;
	logic [WidthW-1:0]  mag_q;
	logic [NarrowW-1:0] vmag_q;

	logic               rsp_valid_q;
	logic               rsp_has_q;
	logic [CmdW-1:0]    rsp_cmd_q;

	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic               req_fire;
	logic               is_read;
	logic               high_ok;
	logic [WidthW-1:0]  high_w;
	logic [WidthW:0]    diff;
	logic [NarrowW-1:0] clamped;
	logic               out_load;

	// config
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q  <= DeadbandRst;
			center_q    <= CenterRst;
			half_span_q <= HalfSpanRst;
			out_range_q <= OutRangeRst;
			pulse_min_q <= PulseMinRst;
			pulse_max_q <= PulseMaxRst;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DEADBAND:  deadband_q  <= cfg.data[NarrowW-1:0];
				REG_CENTER:    center_q    <= cfg.data[WidthW-1:0];
				REG_HALF_SPAN: half_span_q <= cfg.data[WidthW-1:0];
				REG_OUT_RANGE: out_range_q <= cfg.data[NarrowW-1:0];
				REG_PULSE_MIN: pulse_min_q <= cfg.data[WidthW-1:0];
				REG_PULSE_MAX: pulse_max_q <= cfg.data[WidthW-1:0];
				default: ;
			endcase
		end
	end

	// input side
	assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign req_fire  = req.valid && req.ready;
	assign is_read   = (req.operation == OP_READ);

	always_comb begin
		high_ok = 1'b1;
		high_w  = req.width_first;
		priority if (req.level_first && !req.level_second) begin
			high_w = req.width_first;
		end else if (req.level_second && !req.level_first) begin
			high_w = req.width_second;
		end else begin
			high_ok = 1'b0;
		end
	end

	assign diff = {1'b0, latest_q} - {1'b0, center_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latest_q <= '0;
			fresh_q  <= 1'b0;
		end else if (req_fire) begin
			if (is_read) begin
				fresh_q <= 1'b0;
			end else if (high_ok && high_w >= pulse_min_q && high_w <= pulse_max_q) begin
				latest_q <= high_w;
				fresh_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && is_read) begin
			has_q <= fresh_q;
			neg_q <= diff[WidthW];
			mag_q <= diff[WidthW] ? WidthW'(-diff) : diff[WidthW-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = ProdW'(mag_q) * ProdW'(out_range_q);
		div_req.divisor  = half_span_q;
		out_load         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire && is_read) begin
					state_d = fresh_q ? ST_MUL : ST_OUT;
				end
			end
			ST_MUL: begin
				if (half_span_q == '0) begin
					state_d = ST_OUT;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				out_load = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	rcpw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// clamp to out_range; zero half span saturates unless the offset is zero
	assign clamped = (div_rsp.quotient > {{(ProdW-NarrowW){1'b0}}, out_range_q})
		? out_range_q : div_rsp.quotient[NarrowW-1:0];

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL && half_span_q == '0) begin
			vmag_q <= (mag_q != '0) ? out_range_q : '0;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			vmag_q <= clamped;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_has_q <= has_q;
			if (!has_q || vmag_q < deadband_q) begin
				rsp_cmd_q <= '0;
			end else if (neg_q) begin
				rsp_cmd_q <= CmdW'(-{1'b0, vmag_q});
			end else begin
				rsp_cmd_q <= {1'b0, vmag_q};
			end
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.has_value = rsp_has_q;
	assign rsp.command   = rsp_cmd_q;

endmodule
